// ===== rtl/delimited_field_splitter_defines.svh =====
// Assertion helpers used by the top-level splitter to check its own logic.
`ifndef DELIMITED_FIELD_SPLITTER_DEFINES_SVH
`define DELIMITED_FIELD_SPLITTER_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define DFS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("delimited_field_splitter: same-cycle check failed");

// Next-cycle implication, checked while reset is released.
`define DFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("delimited_field_splitter: next-cycle check failed");

`endif

// ===== rtl/dfs_pkg.sv =====
package dfs_pkg;

    localparam int CHAR_W   = 8;
    localparam int START_W  = 12;
    localparam int LENGTH_W = 13;
    localparam int NUMBER_W = 8;

    localparam logic [CHAR_W-1:0] QUOTE_CHAR = 8'h22;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;
    localparam logic [CHAR_W-1:0] SEP_RESET  = 8'h2C;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [START_W-1:0]  field_start;
        logic [LENGTH_W-1:0] field_length;
        logic [NUMBER_W-1:0] field_number;
        logic                last_field;
        logic                overflow;
    } out_item_t;

endpackage

// ===== rtl/delimited_field_splitter.sv =====
// A word accepted from s_data is held in the input register and parsed there; any field
// descriptor it closes is loaded into the result register, which drives m_valid.
// Throughput: one word per cycle. A word that closes a field waits in the input
// register while the previous descriptor is still held, and s_ready then drops.
// Reset (aresetn low, synchronous) empties both registers, clears the line state
// and sets the separator to a comma.
`include "delimited_field_splitter_defines.svh"

module delimited_field_splitter #(
    parameter int MAX_LINE   = 4096,
    parameter int MAX_FIELDS = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  dfs_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output dfs_pkg::out_item_t         m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dfs_pkg::CHAR_W-1:0] cfg_data
);
    import dfs_pkg::*;

    logic [CHAR_W-1:0] separator_reg;
    logic              item_valid;
    in_item_t          item;
    logic              take;
    logic              res_valid;
    out_item_t         res;
    logic              out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg <= SEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            separator_reg <= cfg_data;
        end
    end

    dfs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dfs_parser #(
        .MAX_LINE   (MAX_LINE),
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .separator  (separator_reg),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    dfs_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A descriptor is only produced when the result register can take it.
    `DFS_ASSERT_SAME(a_res_slot_free, aclk, aresetn, res_valid, out_free && take)
    // An accepted word is held in the input register on the next cycle.
    `DFS_ASSERT_NEXT(a_in_loaded, aclk, aresetn, s_valid && s_ready, item_valid)
    // A held word that the parser does not consume stays held.
    `DFS_ASSERT_NEXT(a_in_kept, aclk, aresetn, item_valid && !take, item_valid)

endmodule

// ===== rtl/dfs_in_stage.sv =====
module dfs_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dfs_pkg::in_item_t s_data,
    input  logic              take,
    output logic              item_valid,
    output dfs_pkg::in_item_t item
);
    import dfs_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    // The slot frees in the same cycle the parser consumes the held word.
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// ===== rtl/dfs_parser.sv =====
module dfs_parser #(
    parameter int MAX_LINE   = 4096,
    parameter int MAX_FIELDS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    input  dfs_pkg::in_item_t               item,
    input  logic [dfs_pkg::CHAR_W-1:0]      separator,
    input  logic                            out_free,
    output logic                            take,
    output logic                            res_valid,
    output dfs_pkg::out_item_t              res
);
    import dfs_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE + 1);
    localparam int CNT_W = $clog2(MAX_FIELDS);
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_LINE);
    localparam logic [POS_W-1:0] START_MAX = POS_W'(MAX_LINE - 1);
    localparam logic [POS_W-1:0] POS_TWO   = POS_W'(2);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(MAX_FIELDS - 1);

    logic [POS_W-1:0] position_reg,   position_next;
    logic [POS_W-1:0] span_begin_reg, span_begin_next;
    logic             inside_reg,     inside_next;
    logic             bwq_reg,        bwq_next;
    logic             pwq_reg,        pwq_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic             count_full_reg, count_full_next;
    logic             ovf_reg,        ovf_next;

    logic             eol;
    logic             is_quote;
    logic             is_sep;
    logic             closing;
    logic             at_end;
    logic [POS_W-1:0] len_raw;
    logic             strip;
    logic [POS_W-1:0] start_kept;
    logic [POS_W-1:0] start_clamp;
    logic [POS_W-1:0] len_kept;
    logic [POS_W+START_W-1:0]  start_ext;
    logic [POS_W+LENGTH_W-1:0] len_ext;
    logic [CNT_W+NUMBER_W-1:0] num_ext;

    // A zero byte counts as an end-of-line mark; a quote never separates.
    assign eol      = item.end_of_line || (item.char_in == NUL_CHAR);
    assign is_quote = !eol && (item.char_in == QUOTE_CHAR);
    assign is_sep   = !eol && !is_quote && (item.char_in == separator) && !inside_reg;
    assign closing  = eol || is_sep;
    assign at_end   = (position_reg == POS_MAX);

    // Words that close a field wait for the result register; others pass freely.
    assign take      = item_valid && (!closing || out_free);
    assign res_valid = item_valid && closing && out_free;

    always_comb begin
        len_raw = (position_reg >= span_begin_reg) ? position_reg - span_begin_reg : '0;
        strip   = (len_raw >= POS_TWO) && bwq_reg && pwq_reg;
        if (strip) begin
            start_kept = span_begin_reg + POS_W'(1);
            len_kept   = len_raw - POS_TWO;
        end else begin
            start_kept = span_begin_reg;
            len_kept   = len_raw;
        end
        start_clamp = (start_kept > START_MAX) ? START_MAX : start_kept;
        start_ext   = {{START_W{1'b0}}, start_clamp};
        len_ext     = {{LENGTH_W{1'b0}}, len_kept};
        num_ext     = {{NUMBER_W{1'b0}}, count_reg};

        res.field_start  = start_ext[START_W-1:0];
        res.field_length = len_ext[LENGTH_W-1:0];
        res.field_number = num_ext[NUMBER_W-1:0];
        res.last_field   = eol;
        // A separator at the saturated offset also marks the line as overflowed.
        res.overflow     = ovf_reg || count_full_reg || (!eol && at_end);
    end

    always_comb begin
        position_next   = position_reg;
        span_begin_next = span_begin_reg;
        inside_next     = inside_reg;
        bwq_next        = bwq_reg;
        pwq_next        = pwq_reg;
        count_next      = count_reg;
        count_full_next = count_full_reg;
        ovf_next        = ovf_reg;
        if (eol) begin
            position_next   = '0;
            span_begin_next = '0;
            inside_next     = 1'b0;
            bwq_next        = 1'b0;
            pwq_next        = 1'b0;
            count_next      = '0;
            count_full_next = 1'b0;
            ovf_next        = 1'b0;
        end else begin
            inside_next = inside_reg ^ is_quote;
            pwq_next    = is_quote;
            if (is_quote && (position_reg == span_begin_reg) && !at_end) begin
                bwq_next = 1'b1;
            end
            if (is_sep) begin
                bwq_next        = 1'b0;
                span_begin_next = at_end ? POS_MAX : position_reg + POS_W'(1);
                if (count_full_reg) begin
                    ovf_next = 1'b1;
                end
                if (count_reg < CNT_LAST) begin
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    count_full_next = 1'b1;
                end
            end
            if (at_end) begin
                ovf_next = 1'b1;
            end else begin
                position_next = position_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg   <= '0;
            span_begin_reg <= '0;
            inside_reg     <= 1'b0;
            bwq_reg        <= 1'b0;
            pwq_reg        <= 1'b0;
            count_reg      <= '0;
            count_full_reg <= 1'b0;
            ovf_reg        <= 1'b0;
        end else if (take) begin
            position_reg   <= position_next;
            span_begin_reg <= span_begin_next;
            inside_reg     <= inside_next;
            bwq_reg        <= bwq_next;
            pwq_reg        <= pwq_next;
            count_reg      <= count_next;
            count_full_reg <= count_full_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

// ===== rtl/dfs_out_stage.sv =====
module dfs_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    input  dfs_pkg::out_item_t res,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output dfs_pkg::out_item_t m_data
);
    import dfs_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== tb/delimited_field_splitter_tb.sv =====
module delimited_field_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfs_pkg::*;

    localparam int MAX_LINE       = 4096;
    localparam int MAX_FIELDS     = 256;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [CHAR_W-1:0] TAB_CHAR  = 8'h09;
    localparam logic [CHAR_W-1:0] PIPE_CHAR = 8'h7C;
    localparam logic [CHAR_W-1:0] HIGH_CHAR = 8'hFF;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CHAR_W-1:0] cfg_data  = '0;

    delimited_field_splitter #(
        .MAX_LINE   (MAX_LINE),
        .MAX_FIELDS (MAX_FIELDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    in_item_t    pending_words[$];
    out_item_t   expected_fields[$];
    out_item_t   want_field;
    int unsigned queued_words = 0;
    int unsigned send_gap     = 0;
    int unsigned ready_stall  = 0;
    int unsigned quiet_cycles = 0;
    int          mismatches   = 0;
    bit          holdoff_req  = 1'b0;
    bit          no_idle      = 1'b0;

    // Line parser state mirrored from the block.
    logic [CHAR_W-1:0] sep_reg    = SEP_RESET;
    int unsigned       line_pos   = 0;
    int unsigned       span_start = 0;
    int unsigned       field_idx  = 0;
    bit                in_quotes  = 1'b0;
    bit                lead_quote = 1'b0;
    bit                last_quote = 1'b0;
    bit                idx_full   = 1'b0;
    bit                line_ovf   = 1'b0;

    function automatic out_item_t close_span(int unsigned cur, bit last);
        int unsigned start = span_start;
        int unsigned len = (cur >= span_start) ? cur - span_start : 0;
        out_item_t   d;
        if (len >= 2 && lead_quote && last_quote) begin
            start++;
            len -= 2;
        end
        if (start > MAX_LINE - 1) start = MAX_LINE - 1;
        if (idx_full) line_ovf = 1'b1;
        d.field_number = NUMBER_W'(field_idx);
        if (field_idx < MAX_FIELDS - 1) field_idx++;
        else idx_full = 1'b1;
        d.field_start  = START_W'(start);
        d.field_length = LENGTH_W'(len);
        d.last_field   = last;
        d.overflow     = line_ovf;
        lead_quote = 1'b0;
        span_start = (cur < MAX_LINE) ? cur + 1 : MAX_LINE;
        return d;
    endfunction

    function automatic void predict_word(in_item_t w);
        bit          line_end = w.end_of_line || (w.char_in == NUL_CHAR);
        int unsigned cur = line_pos;
        bit          closes = 1'b0;
        out_item_t   d;
        if (line_end) begin
            expected_fields.push_back(close_span(cur, 1'b1));
            line_pos   = 0;
            span_start = 0;
            field_idx  = 0;
            in_quotes  = 1'b0;
            lead_quote = 1'b0;
            last_quote = 1'b0;
            idx_full   = 1'b0;
            line_ovf   = 1'b0;
            return;
        end
        // The quote test wins, so a quote never acts as a separator.
        if (w.char_in == QUOTE_CHAR) begin
            in_quotes = !in_quotes;
            if (cur == span_start && cur < MAX_LINE) lead_quote = 1'b1;
        end else if (w.char_in == sep_reg && !in_quotes) begin
            d = close_span(cur, 1'b0);
            closes = 1'b1;
        end
        last_quote = (w.char_in == QUOTE_CHAR);
        if (line_pos < MAX_LINE) begin
            line_pos++;
        end else begin
            // Characters past the line limit pile up at the limit and flag the line.
            line_ovf = 1'b1;
            if (closes) d.overflow = 1'b1;
        end
        if (closes) expected_fields.push_back(d);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int field_differs(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Driver: one word per slot, random gaps after accepted words.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_word(s_data);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_words.pop_front();
                    if (!no_idle && $urandom_range(0, 99) < 30) send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each descriptor and throttles m_ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_fields.size() == 0) begin
                    $display("%0t: expected no descriptor, got %p", $time, m_data);
                    mismatches++;
                end else begin
                    want_field = expected_fields.pop_front();
                    mismatches += field_differs("field_start",
                                                16'(want_field.field_start),
                                                16'(m_data.field_start));
                    mismatches += field_differs("field_length",
                                                16'(want_field.field_length),
                                                16'(m_data.field_length));
                    mismatches += field_differs("field_number",
                                                16'(want_field.field_number),
                                                16'(m_data.field_number));
                    mismatches += field_differs("last_field",
                                                16'(want_field.last_field),
                                                16'(m_data.last_field));
                    mismatches += field_differs("overflow",
                                                16'(want_field.overflow),
                                                16'(m_data.overflow));
                end
            end
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                ready_stall = HOLDOFF_CYCLES;
            end
            if (ready_stall > 0) begin
                ready_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 20) ready_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready)
            && !(cfg_valid && cfg_ready)) begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("tb: failure");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    task automatic push_word(logic [CHAR_W-1:0] c, logic eol);
        in_item_t w;
        w.char_in     = c;
        w.end_of_line = eol;
        pending_words.push_back(w);
        queued_words++;
    endtask

    task automatic push_plain();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(1, 255));
        while (c == QUOTE_CHAR || c == sep_reg);
        push_word(c, 1'b0);
    endtask

    task automatic push_line();
        int unsigned n_fields = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14)
                                                            : $urandom_range(1, 5);
        int unsigned kind;
        int unsigned len;
        for (int f = 0; f < n_fields; f++) begin
            if (f != 0) push_word(sep_reg, 1'b0);
            kind = $urandom_range(0, 99);
            len  = $urandom_range(0, 6);
            if (kind < 45) begin
                repeat (len) push_plain();
            end else if (kind < 90) begin
                // Quoted field; separators and doubled quotes may sit inside.
                push_word(QUOTE_CHAR, 1'b0);
                repeat (len) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 25) begin
                        push_word(sep_reg, 1'b0);
                    end else if (kind < 35) begin
                        push_word(QUOTE_CHAR, 1'b0);
                        push_word(QUOTE_CHAR, 1'b0);
                    end else begin
                        push_plain();
                    end
                end
                if ($urandom_range(0, 9) != 0) push_word(QUOTE_CHAR, 1'b0);
            end else begin
                repeat (len) begin
                    if ($urandom_range(0, 2) == 0) push_word(QUOTE_CHAR, 1'b0);
                    else push_plain();
                end
            end
        end
        if ($urandom_range(0, 4) == 0) push_word(NUL_CHAR, 1'b0);
        else push_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // Returns once the block is drained and has had time to settle.
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_fields.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CHAR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sep_reg = value;
    endtask

    task automatic run_random(int unsigned budget);
        int unsigned stop = queued_words + budget;
        while (queued_words < stop) begin
            if ($urandom_range(0, 99) < 80) begin
                push_line();
            end else begin
                repeat ($urandom_range(1, 8))
                    push_word(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Plain, quoted and empty quoted fields.
        push_word("a", 1'b0);
        push_word(SEP_RESET, 1'b0);
        push_word(QUOTE_CHAR, 1'b0);
        push_word("b", 1'b0);
        push_word(QUOTE_CHAR, 1'b0);
        push_word(SEP_RESET, 1'b0);
        push_word(QUOTE_CHAR, 1'b0);
        push_word(QUOTE_CHAR, 1'b0);
        push_word(NUL_CHAR, 1'b1);
        // Separator inside quotes, a lone quote, and a zero byte ending the line.
        push_word(QUOTE_CHAR, 1'b0);
        push_word("x", 1'b0);
        push_word(SEP_RESET, 1'b0);
        push_word("y", 1'b0);
        push_word(QUOTE_CHAR, 1'b0);
        push_word(SEP_RESET, 1'b0);
        push_word(QUOTE_CHAR, 1'b0);
        push_word(NUL_CHAR, 1'b0);
        // Empty line, then byte extremes.
        push_word(HIGH_CHAR, 1'b1);
        push_word(HIGH_CHAR, 1'b0);
        push_word(8'h01, 1'b0);
        push_word(8'h55, 1'b1);
        wait_idle();

        run_random(50);
        cfg_write(TAB_CHAR);
        run_random(25);

        // Receiver stalls while short fields keep coming, so the block backs up.
        holdoff_req = 1'b1;
        repeat (15) begin
            push_plain();
            push_word(sep_reg, 1'b0);
        end
        repeat (2) push_line();
        wait_idle();

        cfg_write(PIPE_CHAR);
        run_random(25);
        cfg_write(QUOTE_CHAR);
        run_random(20);
        cfg_write(NUL_CHAR);
        run_random(15);
        cfg_write(HIGH_CHAR);
        run_random(15);
        cfg_write(SEP_RESET);

        no_idle = 1'b1;
        // More fields than the field number can count.
        repeat (MAX_FIELDS + 2) push_word(sep_reg, 1'b0);
        push_word(NUL_CHAR, 1'b1);
        wait_idle();
        no_idle = 1'b0;

        run_random(15);
        repeat (8) @(posedge aclk);

        if (expected_fields.size() != 0) begin
            $display("%0t: %0d descriptors missing, oldest expected %p, got none", $time,
                     expected_fields.size(), expected_fields[0]);
        end
        if (mismatches == 0 && expected_fields.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
